/* src/etrb_pkg.sv */
// etrb_pkg: shared types and constants for the event trace ring buffer
// used by every module under src; depends on nothing else
`default_nettype none

package etrb_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic KIND_LOG  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_LOGGED = 2'd0,
		ST_RECORD = 2'd1,
		ST_DENIED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_STREAM = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic               kind;
		logic               has_process;
		logic [14:0]        proc_id;
		logic [14:0]        user_id;
		logic [5:0]         call_number;
		logic signed [31:0] call_result;
		logic [31:0]        tick_count;
		logic [6:0]         capacity;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [14:0]        out_proc_id;
		logic signed [15:0] out_user_id;
		logic [5:0]         out_call_number;
		logic signed [31:0] out_call_result;
		logic [31:0]        out_tick;
		logic               last;
		logic [6:0]         records_copied;
	} result_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic log_ack;
		logic deny;
		logic empty;
		logic load;
		logic issue;
	} ctrl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_log;
		logic permit;
		logic any;
		logic at_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/etrb_ctrl.sv */
// etrb_ctrl: state machine that sequences log beats and record readout
// depends on etrb_pkg
`default_nettype none

module etrb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire etrb_pkg::dp_stat_t  stat,
	output etrb_pkg::ctrl_cmd_t      cmd,
	output logic                     busy
);
	import etrb_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && !stat.is_log && stat.permit && stat.any) begin
					state_nxt = S_STREAM;
				end
			end
			S_STREAM: begin
				if (stat.at_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (stat.is_log) begin
						cmd.log_ack = 1'b1;
					end else if (!stat.permit) begin
						cmd.deny = 1'b1;
					end else if (!stat.any) begin
						cmd.empty = 1'b1;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_STREAM: begin
				busy      = 1'b1;
				cmd.issue = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/etrb_dp.sv */
// etrb_dp: record stores, write pointer, live count and readout datapath
// depends on etrb_pkg; driven by etrb_ctrl commands
`default_nettype none

module etrb_dp #(
	parameter int DEPTH = etrb_pkg::DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire etrb_pkg::item_t     item,
	input  wire etrb_pkg::ctrl_cmd_t cmd,
	output etrb_pkg::dp_stat_t       stat,
	output logic                     result_valid,
	output etrb_pkg::result_t        result
);
	import etrb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	// record stores, no reset: only written slots are ever read
	logic [30:0] id_mem   [DEPTH];
	logic [37:0] call_mem [DEPTH];
	logic [31:0] tick_mem [DEPTH];

	logic [PW-1:0] wp_q;
	logic [LW-1:0] live_q;
	logic [PW-1:0] rd_idx_q;
	logic [LW-1:0] rem_q;
	logic [LW-1:0] total_q;

	logic          ack_valid_q;
	status_t       ack_status_q;

	logic          rec_valid_s1;
	logic          last_s1;
	logic [LW-1:0] count_s1;
	logic [30:0]   id_s1;
	logic [37:0]   call_s1;
	logic [31:0]   tick_s1;

	logic [LW-1:0] cap_sat;
	logic [LW-1:0] n_rd;
	logic [PW:0]   start_sum;
	logic [PW-1:0] start_idx;
	logic [15:0]   rec_uid;
	logic [14:0]   rec_pid;

	always_comb begin
		if (item.capacity > 7'(DEPTH)) begin
			cap_sat = LW'(DEPTH);
		end else begin
			cap_sat = LW'(item.capacity);
		end
		n_rd = (live_q > cap_sat) ? cap_sat : live_q;
		// oldest slot of the newest n records, value stays below twice depth
		start_sum = (PW+1)'(wp_q) + (PW+1)'(DEPTH) - (PW+1)'(n_rd);
		if (start_sum >= (PW+1)'(DEPTH)) begin
			start_idx = PW'(start_sum - (PW+1)'(DEPTH));
		end else begin
			start_idx = PW'(start_sum);
		end
		rec_pid = item.has_process ? item.proc_id : 15'd0;
		rec_uid = item.has_process ? {1'b0, item.user_id} : 16'hFFFF;
	end

	assign stat.is_log  = (item.kind == KIND_LOG);
	assign stat.permit  = item.has_process && (item.user_id == 15'd0);
	assign stat.any     = (n_rd != '0);
	assign stat.at_last = (rem_q == LW'(1));

	always_ff @(posedge clk) begin
		if (cmd.log_ack) begin
			id_mem[wp_q]   <= {rec_uid, rec_pid};
			call_mem[wp_q] <= {item.call_result, item.call_number};
			tick_mem[wp_q] <= item.tick_count;
		end
		if (cmd.issue) begin
			id_s1   <= id_mem[rd_idx_q];
			call_s1 <= call_mem[rd_idx_q];
			tick_s1 <= tick_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			live_q       <= '0;
			rd_idx_q     <= '0;
			rem_q        <= '0;
			total_q      <= '0;
			ack_valid_q  <= 1'b0;
			ack_status_q <= ST_LOGGED;
			rec_valid_s1 <= 1'b0;
			last_s1      <= 1'b0;
			count_s1     <= '0;
		end else begin
			ack_valid_q  <= cmd.log_ack || cmd.deny || cmd.empty;
			rec_valid_s1 <= cmd.issue;
			if (cmd.log_ack) begin
				ack_status_q <= ST_LOGGED;
				wp_q         <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
				if (live_q != LW'(DEPTH)) begin
					live_q <= live_q + LW'(1);
				end
			end else if (cmd.deny) begin
				ack_status_q <= ST_DENIED;
			end else if (cmd.empty) begin
				ack_status_q <= ST_EMPTY;
			end
			if (cmd.load) begin
				rd_idx_q <= start_idx;
				rem_q    <= n_rd;
				total_q  <= n_rd;
			end else if (cmd.issue) begin
				rd_idx_q <= (rd_idx_q == PW'(DEPTH - 1)) ? '0 : rd_idx_q + PW'(1);
				rem_q    <= rem_q - LW'(1);
			end
			if (cmd.issue) begin
				last_s1  <= stat.at_last;
				count_s1 <= stat.at_last ? total_q : '0;
			end
		end
	end

	// single-beat answers carry zeros in every field but status and last
	always_comb begin
		result = '0;
		if (rec_valid_s1) begin
			result.status          = ST_RECORD;
			result.out_proc_id     = id_s1[14:0];
			result.out_user_id     = id_s1[30:15];
			result.out_call_number = call_s1[5:0];
			result.out_call_result = call_s1[37:6];
			result.out_tick        = tick_s1;
			result.last            = last_s1;
			result.records_copied  = 7'(count_s1);
		end else begin
			result.status = ack_status_q;
			result.last   = 1'b1;
		end
	end

	assign result_valid = ack_valid_q || rec_valid_s1;

endmodule

`default_nettype wire

/* src/event_trace_ring_buffer_core.sv */
// event trace ring buffer, top level: controller plus datapath
// every result beat is registered after the command that produced it;
// a log, denied or empty read answers in the cycle after acceptance, busy stays low,
// so one log item per cycle is sustained. a permitted read of n records holds
// busy until its last record is issued and delivers one record per cycle, the first
// following the pointer load and the s1 read register, limited by the single read port of the stores.
// arst_n clears pointer, live count and control; record stores are not cleared.
`default_nettype none

module event_trace_ring_buffer_core #(
	parameter int DEPTH = etrb_pkg::DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire etrb_pkg::item_t  item,
	output logic                  busy,
	output logic                  result_valid,
	output etrb_pkg::result_t     result
);
	import etrb_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	etrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	etrb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

/* src/etrb_chk.sv */
// etrb_chk: port-level checks for the event trace ring buffer, bound to the top
// depends on etrb_pkg and event_trace_ring_buffer_core
`default_nettype none

module etrb_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire etrb_pkg::item_t   item,
	input wire logic              busy,
	input wire logic              result_valid,
	input wire etrb_pkg::result_t result
);
	import etrb_pkg::*;

	// a log beat is acknowledged on the very next cycle
	a_log_ack: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == KIND_LOG
		|=> result_valid && result.status == ST_LOGGED && result.last)
		else $error("log beat not acknowledged");

	// a read without a process or from a nonzero user is denied next cycle
	a_deny: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == KIND_READ
		&& (!item.has_process || item.user_id != 15'd0)
		|=> result_valid && result.status == ST_DENIED && result.last)
		else $error("read not denied");

	// only records may be non-final beats
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_RECORD
		|-> result.last && result.records_copied == 7'd0)
		else $error("single beat malformed");

	// more records pending means no new item can be taken
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("idle while records pending");

endmodule

bind event_trace_ring_buffer_core etrb_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
